[rtl/core/bpe_pkg.sv]
// Shared types and constants for the button press event classifier.
package bpe_pkg;

  typedef enum logic [1:0] {
    EV_DOWN  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_TURN  = 2'd3
  } event_kind_t;

  localparam logic [2:0] ENC_R_ID = 3'd4;
  localparam logic [2:0] ENC_L_ID = 3'd5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_REVERSE = 1'b1;

  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic        evt_v;
    event_kind_t kind;
    logic        is_long;
    logic [15:0] dur;
  } lane_res_t;

  typedef struct packed {
    logic              r_v;
    logic signed [7:0] r_turn;
    logic              l_v;
    logic signed [7:0] l_turn;
  } enc_res_t;

endpackage

[rtl/core/button_press_event_classifier.sv]
// Top level of the button press event classifier.
// One input beat is one tick. On acceptance the tick counter advances, every button
// lane compares its press stamp against the new tick and the encoder steps are reversed
// as configured; the registered lane results are then merged into an event buffer once
// it is free, and the serializer sends one event per cycle into the output register
// while the output is not stalled, lowest button first, then right and left encoder.
// A tick holds the buffer until its last event leaves it (at most NUM_BUTTONS + 2
// events); that serializer sets the throughput, and a new tick is taken in the same
// cycle the previous one's last event leaves. Each event passes the lane registers,
// the event buffer and the output register. A tick with no events produces no output beat.
module button_press_event_classifier import bpe_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_button_levels,
  input  logic signed [7:0]    in_right_step,
  input  logic signed [7:0]    in_left_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [2:0]           out_control_id,
  output logic signed [7:0]    out_turn_amount,
  output logic [3:0]           out_held_mask,
  output logic [15:0]          out_hold_ticks,
  output logic                 out_last_event
);

  localparam int CW = (NUM_BUTTONS > 4) ? NUM_BUTTONS : 4;
  localparam logic [CW-1:0] BTN_MASK = CW'((1 << NUM_BUTTONS) - 1);

  logic [15:0]       thr_r;
  logic [1:0]        rev_r;
  logic [31:0]       tick_r, now;
  logic              a_v_r, a_load, a_take;
  logic [CW-1:0]     lvl_in, a_lvl_r;
  enc_res_t          enc_nxt, enc_r;
  lane_res_t [NUM_BUTTONS-1:0] lanes;

  assign in_stall = a_v_r && !a_take;
  assign a_load   = in_valid && !in_stall;
  assign now      = tick_r + 32'd1;
  assign lvl_in   = CW'(in_button_levels) & BTN_MASK;

  always_comb begin
    enc_nxt.r_v    = (in_right_step != 8'sd0);
    enc_nxt.r_turn = rev_r[0] ? -in_right_step : in_right_step;
    enc_nxt.l_v    = (in_left_step != 8'sd0);
    enc_nxt.l_turn = rev_r[1] ? -in_left_step : in_left_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= LONG_PRESS_RST;
      rev_r  <= 2'd0;
      tick_r <= '0;
      a_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PRESS:  thr_r <= cfg_wdata;
          CFG_ENC_REVERSE: rev_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (a_load) begin
        tick_r <= now;
        a_v_r  <= 1'b1;
      end else if (a_take) begin
        a_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_lvl_r <= lvl_in;
      enc_r   <= enc_nxt;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bpe_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (a_load),
      .level (lvl_in[i]),
      .now   (now),
      .thr   (thr_r),
      .res_r (lanes[i])
    );
  end

  bpe_merge #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .CW          (CW)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .a_valid         (a_v_r),
    .a_take          (a_take),
    .lvl             (a_lvl_r),
    .lanes           (lanes),
    .enc             (enc_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_event_kind  (out_event_kind),
    .out_control_id  (out_control_id),
    .out_turn_amount (out_turn_amount),
    .out_held_mask   (out_held_mask),
    .out_hold_ticks  (out_hold_ticks),
    .out_last_event  (out_last_event)
  );

  a_turn_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_kind == EV_TURN) ==
                   (out_control_id == ENC_R_ID || out_control_id == ENC_L_ID)))
    else $error("turn event and encoder id disagree");

  a_button_turn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_TURN |-> out_turn_amount == 8'sd0)
    else $error("button event carries a turn amount");

  a_no_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_DOWN || out_event_kind == EV_TURN)
      |-> out_hold_ticks == 16'd0)
    else $error("down or turn event carries a hold duration");

  a_long_unheld: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_LONG |-> !out_held_mask[out_control_id[1:0]])
    else $error("long press button still in held mask");

endmodule

[rtl/core/bpe_lane.sv]
// Per-button lane: edge detection, press stamp and hold classification.
module bpe_lane import bpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        level,
  input  logic [31:0] now,
  input  logic [15:0] thr,
  output lane_res_t   res_r
);

  logic [31:0] stamp_r, stamp_nxt;
  logic        prev_r;
  logic [31:0] t;
  logic        rise, fall, hit;
  lane_res_t   res_nxt;

  always_comb begin
    t    = now - stamp_r;
    rise = level & ~prev_r;
    fall = ~level & prev_r;
    hit  = level & prev_r & (t == {16'd0, thr});
    stamp_nxt = stamp_r;
    if (rise) begin
      stamp_nxt = now;
    end else if (fall) begin
      stamp_nxt = '0;
    end
    res_nxt.evt_v   = rise | (fall & (t < {16'd0, thr})) | hit;
    res_nxt.kind    = rise ? EV_DOWN : (fall ? EV_SHORT : EV_LONG);
    res_nxt.is_long = hit;
    res_nxt.dur     = rise ? 16'd0 : t[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      prev_r  <= 1'b0;
    end else if (load) begin
      stamp_r <= stamp_nxt;
      prev_r  <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/core/bpe_merge.sv]
// Merge of lane results into an event buffer and serializer to the output register.
module bpe_merge import bpe_pkg::*; #(
  parameter int NUM_BUTTONS = 4,
  parameter int CW          = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         a_valid,
  output logic                         a_take,
  input  logic [CW-1:0]                lvl,
  input  lane_res_t [NUM_BUTTONS-1:0]  lanes,
  input  enc_res_t                     enc,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [1:0]                   out_event_kind,
  output logic [2:0]                   out_control_id,
  output logic signed [7:0]            out_turn_amount,
  output logic [3:0]                   out_held_mask,
  output logic [15:0]                  out_hold_ticks,
  output logic                         out_last_event
);

  localparam int NS = NUM_BUTTONS + 2;
  localparam int SW = $clog2(NS);

  logic [NS-1:0]     pend_r, pend_nxt, cand, sel_oh, pend_left;
  event_kind_t       kind_r [NS];
  event_kind_t       kind_c [NS];
  logic [3:0]        held_r [NS];
  logic [3:0]        held_c [NS];
  logic [15:0]       dur_r  [NS];
  logic [15:0]       dur_c  [NS];
  logic signed [7:0] turn_r [NS];
  logic signed [7:0] turn_c [NS];
  logic [CW-1:0]     cum;
  logic [SW-1:0]     sel;
  logic              o_load, pop, load_b;
  logic [2:0]        sel_id;

  logic              ov_r, last_r;
  event_kind_t       okind_r;
  logic [2:0]        oid_r;
  logic signed [7:0] oturn_r;
  logic [3:0]        oheld_r;
  logic [15:0]       odur_r;

  always_comb begin
    sel = '0;
    for (int s = NS - 1; s >= 0; s--) begin
      if (pend_r[s]) begin
        sel = SW'(s);
      end
    end
    sel_oh    = NS'(1) << sel;
    o_load    = !ov_r || !out_stall;
    pop       = o_load && (|pend_r);
    pend_left = pop ? (pend_r & ~sel_oh) : pend_r;
    a_take    = (pend_left == '0);
    load_b    = a_valid && a_take;
    pend_nxt  = load_b ? cand : pend_left;

    if (sel == SW'(NUM_BUTTONS)) begin
      sel_id = ENC_R_ID;
    end else if (sel == SW'(NUM_BUTTONS + 1)) begin
      sel_id = ENC_L_ID;
    end else begin
      sel_id = 3'(sel);
    end
  end

  always_comb begin
    cum = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cum[i]    = lanes[i].is_long;
      cand[i]   = lanes[i].evt_v;
      kind_c[i] = lanes[i].kind;
      held_c[i] = 4'(lvl & ~cum);
      dur_c[i]  = lanes[i].dur;
      turn_c[i] = '0;
    end
    cand[NUM_BUTTONS]       = enc.r_v;
    kind_c[NUM_BUTTONS]     = EV_TURN;
    held_c[NUM_BUTTONS]     = 4'(lvl & ~cum);
    dur_c[NUM_BUTTONS]      = '0;
    turn_c[NUM_BUTTONS]     = enc.r_turn;
    cand[NUM_BUTTONS + 1]   = enc.l_v;
    kind_c[NUM_BUTTONS + 1] = EV_TURN;
    held_c[NUM_BUTTONS + 1] = 4'(lvl & ~cum);
    dur_c[NUM_BUTTONS + 1]  = '0;
    turn_c[NUM_BUTTONS + 1] = enc.l_turn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (pop) begin
        ov_r <= 1'b1;
      end else if (o_load) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      for (int s = 0; s < NS; s++) begin
        kind_r[s] <= kind_c[s];
        held_r[s] <= held_c[s];
        dur_r[s]  <= dur_c[s];
        turn_r[s] <= turn_c[s];
      end
    end
    if (pop) begin
      okind_r <= kind_r[sel];
      oid_r   <= sel_id;
      oturn_r <= turn_r[sel];
      oheld_r <= held_r[sel];
      odur_r  <= dur_r[sel];
      last_r  <= (pend_left == '0);
    end
  end

  assign out_valid       = ov_r;
  assign out_event_kind  = okind_r;
  assign out_control_id  = oid_r;
  assign out_turn_amount = oturn_r;
  assign out_held_mask   = oheld_r;
  assign out_hold_ticks  = odur_r;
  assign out_last_event  = last_r;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the button press event classifier.
module tb_top import bpe_pkg::*;;

  typedef struct packed {
    logic [3:0]        levels;
    logic signed [7:0] right;
    logic signed [7:0] left;
  } tick_item_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [2:0]        id;
    logic signed [7:0] turn;
    logic [3:0]        held;
    logic [15:0]       dur;
    logic              last;
  } press_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LONG_PRESS;
  logic [15:0]          cfg_wdata = 16'd0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [3:0]           in_button_levels = 4'd0;
  logic signed [7:0]    in_right_step = 8'sd0;
  logic signed [7:0]    in_left_step = 8'sd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_event_kind;
  logic [2:0]           out_control_id;
  logic signed [7:0]    out_turn_amount;
  logic [3:0]           out_held_mask;
  logic [15:0]          out_hold_ticks;
  logic                 out_last_event;

  button_press_event_classifier dut (.*);

  // predictor state
  logic [31:0]  tick_now = 32'd0;
  logic [31:0]  press_time [4] = '{default: 32'd0};
  logic [3:0]   prev_levels = 4'd0;
  logic [15:0]  thr_ticks = LONG_PRESS_RST;
  logic [1:0]   rev_sel = 2'd0;

  tick_item_t   pending_ticks [$];
  press_event_t expected_events [$];
  int           in_flight = 0;
  int           errors = 0;
  logic         calm = 1'b0;
  logic [3:0]   gen_levels = 4'd0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic press_event_t make_event(event_kind_t kind, logic [2:0] id,
                                              logic signed [7:0] turn, logic [3:0] held,
                                              logic [15:0] dur);
    press_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.turn = turn;
    ev.held = held;
    ev.dur  = dur;
    ev.last = 1'b0;
    return ev;
  endfunction

  task automatic classify_tick(input logic [3:0] lv, input logic signed [7:0] rs,
                               input logic signed [7:0] ls);
    press_event_t batch [$];
    logic [31:0]  elapsed;
    logic [3:0]   held;
    logic signed [7:0] amt;
    tick_now = tick_now + 32'd1;
    held = lv;
    for (int i = 0; i < 4; i++) begin
      elapsed = tick_now - press_time[i];
      if (lv[i] && !prev_levels[i]) begin
        press_time[i] = tick_now;
        batch.push_back(make_event(EV_DOWN, 3'(i), 8'sd0, held, 16'd0));
      end else if (!lv[i] && prev_levels[i]) begin
        if (elapsed < {16'd0, thr_ticks})
          batch.push_back(make_event(EV_SHORT, 3'(i), 8'sd0, held, elapsed[15:0]));
        press_time[i] = 32'd0;
      end else if (lv[i] && elapsed == {16'd0, thr_ticks}) begin
        held[i] = 1'b0;
        batch.push_back(make_event(EV_LONG, 3'(i), 8'sd0, held, elapsed[15:0]));
      end
    end
    if (rs != 8'sd0) begin
      amt = rev_sel[0] ? -rs : rs;
      batch.push_back(make_event(EV_TURN, ENC_R_ID, amt, held, 16'd0));
    end
    if (ls != 8'sd0) begin
      amt = rev_sel[1] ? -ls : ls;
      batch.push_back(make_event(EV_TURN, ENC_L_ID, amt, held, 16'd0));
    end
    prev_levels = lv;
    if (batch.size() != 0)
      batch[batch.size()-1].last = 1'b1;
    foreach (batch[k])
      expected_events.push_back(batch[k]);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // driver
  always @(posedge clk) begin
    tick_item_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        classify_tick(in_button_levels, in_right_step, in_left_step);
        in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
          nxt = pending_ticks.pop_front();
          in_valid         <= 1'b1;
          in_button_levels <= nxt.levels;
          in_right_step    <= nxt.right;
          in_left_step     <= nxt.left;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    press_event_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          log_mismatch($sformatf("unexpected beat kind %0d id %0d",
                                 out_event_kind, out_control_id));
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 16'(out_event_kind), 16'(want.kind));
          check_field("control_id", 16'(out_control_id), 16'(want.id));
          check_field("turn_amount", 16'(8'(out_turn_amount)), 16'(8'(want.turn)));
          check_field("held_mask", 16'(out_held_mask), 16'(want.held));
          check_field("hold_ticks", out_hold_ticks, want.dur);
          check_field("last_event", 16'(out_last_event), 16'(want.last));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  task automatic queue_tick(input logic [3:0] lv, input logic signed [7:0] rs,
                            input logic signed [7:0] ls);
    tick_item_t it;
    it.levels = lv;
    it.right  = rs;
    it.left   = ls;
    in_flight++;
    pending_ticks.push_back(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((in_flight != 0 || expected_events.size() != 0) && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LONG_PRESS)
      thr_ticks = data;
    else
      rev_sel = data[1:0];
  endtask

  function automatic logic signed [7:0] rand_step();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'sd0;
      5:             return $urandom_range(1) ? 8'sd127 : -8'sd128;
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [3:0] flip;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0) begin
        gen_levels = 4'($urandom_range(15));
      end else begin
        for (int b = 0; b < 4; b++)
          flip[b] = ($urandom_range(99) < 22);
        gen_levels = gen_levels ^ flip;
      end
      queue_tick(gen_levels, rand_step(), rand_step());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default threshold, no reversal
    queue_tick(4'h0, 8'sd0, 8'sd0);
    queue_tick(4'hF, 8'sd5, -8'sd5);
    queue_tick(4'hF, 8'sd0, 8'sd0);
    queue_tick(4'hC, 8'sd127, 8'sd0);
    queue_tick(4'h0, -8'sd128, 8'sd127);
    queue_tick(4'hA, 8'sd0, 8'sd1);
    queue_tick(4'h5, 8'sd0, 8'sd0);
    queue_tick(4'h0, 8'sd0, 8'sd0);
    drain();

    // short threshold, both encoders reversed
    write_reg(CFG_LONG_PRESS, 16'd3);
    write_reg(CFG_ENC_REVERSE, 16'd3);
    queue_tick(4'hF, -8'sd128, -8'sd128);
    queue_tick(4'hF, 8'sd0, 8'sd0);
    queue_tick(4'hF, 8'sd0, 8'sd0);
    queue_tick(4'hF, 8'sd1, -8'sd1);
    queue_tick(4'h0, 8'sd0, 8'sd0);
    queue_tick(4'h1, 8'sd0, 8'sd0);
    queue_tick(4'h1, 8'sd0, 8'sd0);
    queue_tick(4'h0, 8'sd0, 8'sd0);
    queue_tick(4'h2, 8'sd0, 8'sd0);
    queue_tick(4'h0, 8'sd127, 8'sd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] thr;
      logic [1:0]  rev;
      case (ph)
        0: begin thr = 16'd1;     rev = 2'd0; end
        1: begin thr = 16'd2;     rev = 2'd3; end
        2: begin thr = 16'd4;     rev = 2'd1; end
        3: begin thr = 16'd7;     rev = 2'd2; end
        4: begin thr = 16'd12;    rev = 2'd0; end
        5: begin thr = 16'd65535; rev = 2'd3; end
        6: begin thr = 16'd0;     rev = 2'd2; end
        default: begin
          thr = 16'($urandom_range(20, 1));
          rev = 2'($urandom_range(3));
        end
      endcase
      write_reg(CFG_LONG_PRESS, thr);
      write_reg(CFG_ENC_REVERSE, 16'(rev));
      calm = (ph == 4);
      run_random(36);
      drain();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (expected_events.size() != 0)
      log_mismatch($sformatf("%0d events never arrived", expected_events.size()));
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
